// ===== design/msb_pkg.sv =====
// Package for the merge sort buffer: default sizes, controller state type and the
// command and status structs between the controller and the datapath. No dependencies.
`default_nettype none

package msb_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_PASS_CHECK,
      ST_RUN_CHECK,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic sort_init;
      logic pass_next;
      logic run_init;
      logic merge_step;
      logic emit_init;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic pass_done;
      logic runs_done;
      logic run_end;
      logic emit_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/msb_datapath.sv =====
// Datapath of the merge sort buffer: the two ping-pong buffers, the load counter,
// the merge pointers and the result registers. Depends on msb_pkg.
`default_nettype none

module msb_datapath #(
   parameter int DEPTH = msb_pkg::DEPTH_DEF,
   parameter int WIDTH = msb_pkg::WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire msb_pkg::dp_cmd_type    cmd,
   output msb_pkg::dp_status_type      status,
   input  wire logic signed [WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   output logic signed [WIDTH-1:0]     rsp_value_res,
   output logic                        rsp_last_res
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int W_W   = CNT_W + 1;
   localparam int SUM_W = CNT_W + 2;

   logic [WIDTH-1:0] mem_a [DEPTH];
   logic [WIDTH-1:0] mem_b [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [W_W-1:0]   w_ff, w_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             src_sel_ff, src_sel_in;
   logic [WIDTH-1:0] rd_i_ff;
   logic [WIDTH-1:0] rd_j_ff;
   logic             valid_ff;
   logic             last_ff;

   logic [SUM_W-1:0] mid_sum;
   logic [SUM_W-1:0] hi_sum;
   logic [CNT_W-1:0] mid_calc;
   logic [CNT_W-1:0] hi_calc;
   logic             not_full;
   logic             take_left;
   logic [WIDTH-1:0] merge_data;
   logic             wr_a_en;
   logic [IDX_W-1:0] wr_a_addr;
   logic [WIDTH-1:0] wr_a_data;
   logic             wr_b_en;

   assign not_full = (count_ff < CNT_W'(DEPTH));
   assign mid_sum  = SUM_W'(lo_ff) + SUM_W'(w_ff);
   assign hi_sum   = SUM_W'(lo_ff) + SUM_W'({w_ff, 1'b0});
   assign mid_calc = (mid_sum < SUM_W'(count_ff)) ? mid_sum[CNT_W-1:0] : count_ff;
   assign hi_calc  = (hi_sum < SUM_W'(count_ff)) ? hi_sum[CNT_W-1:0] : count_ff;

   assign take_left = (i_ff < mid_ff) &&
                      ((j_ff >= hi_ff) || ($signed(rd_i_ff) <= $signed(rd_j_ff)));
   assign merge_data = take_left ? rd_i_ff : rd_j_ff;

   assign status.pass_done = (W_W'(count_ff) <= w_ff);
   assign status.runs_done = (lo_ff >= count_ff);
   assign status.run_end   = (CNT_W'(k_ff + CNT_W'(1)) == hi_ff);
   assign status.emit_last = (CNT_W'(i_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      wr_a_en   = 1'b0;
      wr_a_addr = k_ff[IDX_W-1:0];
      wr_a_data = merge_data;
      wr_b_en   = cmd.merge_step && !src_sel_ff;
      if (cmd.load_wr && not_full) begin
         wr_a_en   = 1'b1;
         wr_a_addr = count_ff[IDX_W-1:0];
         wr_a_data = req_value;
      end else if (cmd.merge_step && src_sel_ff) begin
         wr_a_en = 1'b1;
      end
   end

   always_comb begin
      count_in   = count_ff;
      w_in       = w_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      src_sel_in = src_sel_ff;
      if (cmd.load_wr && not_full) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end
      if (cmd.sort_init) begin
         w_in       = W_W'(1);
         lo_in      = '0;
         src_sel_in = 1'b0;
      end
      if (cmd.pass_next) begin
         w_in       = {w_ff[W_W-2:0], 1'b0};
         lo_in      = '0;
         src_sel_in = ~src_sel_ff;
      end
      if (cmd.run_init) begin
         i_in   = lo_ff;
         j_in   = mid_calc;
         k_in   = lo_ff;
         mid_in = mid_calc;
         hi_in  = hi_calc;
      end
      if (cmd.merge_step) begin
         if (take_left) begin
            i_in = CNT_W'(i_ff + CNT_W'(1));
         end else begin
            j_in = CNT_W'(j_ff + CNT_W'(1));
         end
         k_in = CNT_W'(k_ff + CNT_W'(1));
         if (status.run_end) begin
            lo_in = hi_ff;
         end
      end
      if (cmd.emit_init) begin
         i_in = '0;
      end
      if (cmd.emit) begin
         i_in = CNT_W'(i_ff + CNT_W'(1));
         if (status.emit_last) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.emit;
         last_ff  <= cmd.emit && status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      lo_ff      <= lo_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      src_sel_ff <= src_sel_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_a_addr] <= wr_a_data;
      end
      if (wr_b_en) begin
         mem_b[k_ff[IDX_W-1:0]] <= merge_data;
      end
   end

   always_ff @(posedge clock) begin
      if (src_sel_ff) begin
         rd_i_ff <= mem_b[i_ff[IDX_W-1:0]];
         rd_j_ff <= mem_b[j_ff[IDX_W-1:0]];
      end else begin
         rd_i_ff <= mem_a[i_ff[IDX_W-1:0]];
         rd_j_ff <= mem_a[j_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_value_res = rd_i_ff;
   assign rsp_last_res  = last_ff;

endmodule

`default_nettype wire

// ===== design/msb_controller.sv =====
// Controller of the merge sort buffer: sequences load, merge passes and emission.
// Depends on msb_pkg.
`default_nettype none

module msb_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_last,
   input  wire msb_pkg::dp_status_type status,
   output msb_pkg::dp_cmd_type        cmd,
   output logic                       busy
);

   msb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msb_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         msb_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_wr = 1'b1;
               if (req_last) begin
                  state_in = msb_pkg::ST_SORT_INIT;
               end
            end
         end
         msb_pkg::ST_SORT_INIT: begin
            cmd.sort_init = 1'b1;
            state_in      = msb_pkg::ST_PASS_CHECK;
         end
         msb_pkg::ST_PASS_CHECK: begin
            if (status.pass_done) begin
               cmd.emit_init = 1'b1;
               state_in      = msb_pkg::ST_EMIT;
            end else begin
               state_in = msb_pkg::ST_RUN_CHECK;
            end
         end
         msb_pkg::ST_RUN_CHECK: begin
            if (status.runs_done) begin
               cmd.pass_next = 1'b1;
               state_in      = msb_pkg::ST_PASS_CHECK;
            end else begin
               cmd.run_init = 1'b1;
               state_in     = msb_pkg::ST_MERGE_RD;
            end
         end
         msb_pkg::ST_MERGE_RD: begin
            state_in = msb_pkg::ST_MERGE_WR;
         end
         msb_pkg::ST_MERGE_WR: begin
            cmd.merge_step = 1'b1;
            if (status.run_end) begin
               state_in = msb_pkg::ST_RUN_CHECK;
            end else begin
               state_in = msb_pkg::ST_MERGE_RD;
            end
         end
         msb_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = msb_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = msb_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/merge_sort_buffer.sv =====
// Top level of the merge sort buffer: joins the controller and the datapath.
// Depends on msb_pkg, msb_controller and msb_datapath.
//
// Each transaction loads one signed value while busy is low; values beyond
// DEPTH are dropped. A transaction with req_last set starts a stable ascending
// sort of the n loaded values, a bottom-up merge between two buffers in
// ceil(log2 n) passes, each run merged by a read-compare-write loop of the states
// ST_MERGE_RD and ST_MERGE_WR. ST_SORT_INIT sets up the sort before the first pass.
// The n results then stream out one per cycle on rsp_valid, the final one marked
// by rsp_last_res; the receiver cannot stall them. Busy drops again with the last
// result, so the next set may start loading in the cycle that result is shown.
`default_nettype none

module merge_sort_buffer #(
   parameter int DEPTH = msb_pkg::DEPTH_DEF,
   parameter int WIDTH = msb_pkg::WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [WIDTH-1:0] req_value,
   input  wire logic                    req_last,
   output logic                         rsp_valid,
   output logic signed [WIDTH-1:0]      rsp_value_res,
   output logic                         rsp_last_res
);

   msb_pkg::dp_cmd_type    cmd;
   msb_pkg::dp_status_type status;

   msb_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   msb_datapath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("Result strobe without a sort in progress.");

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_res |-> rsp_valid)
      else $error("Final-result mark without a result strobe.");

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> busy)
      else $error("Final transaction did not start a sort.");

   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && $past(!reset)) |-> !rsp_valid)
      else $error("Result strobe in the first cycle of a sort.");

endmodule

`default_nettype wire

// ===== test/merge_sort_checker.sv =====
// Checker for the merge sort buffer: watches the load and result channels, predicts
// each sorted set and compares every result with it. Uses only its own parameters.
module merge_sort_checker #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    busy,
   input  wire logic signed [WIDTH-1:0] req_value,
   input  wire logic                    req_last,
   input  wire logic                    rsp_valid,
   input  wire logic signed [WIDTH-1:0] rsp_value_res,
   input  wire logic                    rsp_last_res,
   output int                           fail_count,
   output int                           pending,
   output int                           results_checked
);

   typedef struct packed {
      logic signed [WIDTH-1:0] value;
      logic                    last;
   } sorted_elem_type;

   logic signed [WIDTH-1:0] loaded_set[$];
   sorted_elem_type         sorted_out[$];
   sorted_elem_type         head;
   sorted_elem_type         elem;
   int                      pos;
   int                      errors = 0;
   int                      checked = 0;

   always @(posedge clock) begin
      if (reset) begin
         loaded_set.delete();
         sorted_out.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (sorted_out.size() == 0) begin
               $error("unexpected result: value_res %0d last_res %0b",
                      rsp_value_res, rsp_last_res);
               errors++;
            end else begin
               head = sorted_out.pop_front();
               if (rsp_value_res !== head.value) begin
                  $error("value_res: expected %0d, actual %0d", head.value, rsp_value_res);
                  errors++;
               end
               if (rsp_last_res !== head.last) begin
                  $error("last_res: expected %0b, actual %0b", head.last, rsp_last_res);
                  errors++;
               end
               checked++;
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            // Insertion behind every equal value keeps the order stable.
            if (loaded_set.size() < DEPTH) begin
               pos = loaded_set.size();
               while (pos > 0 && loaded_set[pos-1] > req_value)
                  pos--;
               loaded_set.insert(pos, req_value);
            end
            if (req_last) begin
               foreach (loaded_set[k]) begin
                  elem.value = loaded_set[k];
                  elem.last  = (k == loaded_set.size() - 1);
                  sorted_out.insert(sorted_out.size(), elem);
               end
               loaded_set.delete();
            end
         end
      end
      fail_count      <= errors;
      pending         <= sorted_out.size();
      results_checked <= checked;
   end

endmodule

// ===== test/merge_sort_buffer_tb.sv =====
// Testbench top for the merge sort buffer: drives sets of signed values and reports
// the verdict. Depends on msb_pkg, merge_sort_buffer and merge_sort_checker.
module merge_sort_buffer_tb;

   localparam int DEPTH = msb_pkg::DEPTH_DEF;
   localparam int WIDTH = msb_pkg::WIDTH_DEF;
   localparam int LOAD_TARGET = 230;

   typedef enum int {
      MIX_WIDE,
      MIX_TIES,
      MIX_EDGES
   } value_mix_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [WIDTH-1:0] req_value;
   logic                    req_last;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_value_res;
   logic                    rsp_last_res;
   int                      fail_count;
   int                      pending;
   int                      results_checked;
   int                      loads_sent = 0;
   int                      sets_sent = 0;
   bit                      gaps_on = 1'b1;

   merge_sort_buffer #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_value_res(rsp_value_res),
      .rsp_last_res(rsp_last_res)
   );

   merge_sort_checker #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_value_res(rsp_value_res),
      .rsp_last_res(rsp_last_res),
      .fail_count(fail_count),
      .pending(pending),
      .results_checked(results_checked)
   );

   always #2 clock = ~clock;

   initial begin
      #1000000;
      $display("merge_sort_buffer_tb: errors");
      $finish;
   end

   function automatic logic signed [WIDTH-1:0] pick_value(input value_mix_type mix);
      case (mix)
         MIX_TIES: begin
            pick_value = int'($urandom_range(0, 6)) - 3;
         end
         MIX_EDGES: begin
            case ($urandom_range(0, 4))
               0: pick_value = {1'b1, {(WIDTH-1){1'b0}}};
               1: pick_value = {1'b0, {(WIDTH-1){1'b1}}};
               2: pick_value = '0;
               3: pick_value = '1;
               default: pick_value = $urandom;
            endcase
         end
         default: begin
            pick_value = $urandom;
         end
      endcase
   endfunction

   task automatic load_value(input logic signed [WIDTH-1:0] value, input logic last);
      logic taken;
      while (gaps_on && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end while (!taken);
      loads_sent++;
      if (last)
         sets_sent++;
   endtask

   task automatic load_set(input int n, input value_mix_type mix);
      for (int i = 0; i < n; i++)
         load_value(pick_value(mix), i == n - 1);
   endtask

   initial begin
      int n;
      start     <= 1'b0;
      req_value <= '0;
      req_last  <= 1'b0;
      reset     <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Single-element sets at both extremes.
      load_value({1'b0, {(WIDTH-1){1'b1}}}, 1'b1);
      load_value({1'b1, {(WIDTH-1){1'b0}}}, 1'b1);
      // Extremes mixed with values around zero.
      load_value({1'b0, {(WIDTH-1){1'b1}}}, 1'b0);
      load_value({1'b1, {(WIDTH-1){1'b0}}}, 1'b0);
      load_value(0, 1'b0);
      load_value(-1, 1'b0);
      load_value(1, 1'b1);
      // Repeated values must keep their load order.
      load_value(5, 1'b0);
      load_value(-3, 1'b0);
      load_value(5, 1'b0);
      load_value(-3, 1'b0);
      load_value(5, 1'b1);
      // A descending set and an already sorted pair.
      for (int i = 3; i >= -2; i--)
         load_value(i, i == -2);
      load_value(-7, 1'b0);
      load_value(7, 1'b1);

      // A full buffer loaded without any idle cycle, then an overfilled one whose
      // final transaction arrives on the full buffer and is dropped.
      gaps_on = 1'b0;
      load_set(DEPTH, MIX_WIDE);
      gaps_on = 1'b1;
      load_set(DEPTH + 2, MIX_TIES);

      while (loads_sent < LOAD_TARGET) begin
         if ($urandom_range(0, 5) == 0)
            n = $urandom_range(13, 40);
         else
            n = $urandom_range(1, 12);
         load_set(n, value_mix_type'($urandom_range(0, 2)));
      end
      start    <= 1'b0;
      req_last <= 1'b0;

      do
         @(negedge clock);
      while (pending != 0);
      repeat (40) @(posedge clock);

      $display("summary: %0d transactions in %0d sets loaded, %0d sorted results checked",
               loads_sent, sets_sent, results_checked);
      if (fail_count == 0) begin
         $display("merge_sort_buffer_tb: clean");
      end else begin
         $display("merge_sort_buffer_tb: errors");
      end
      $finish;
   end

endmodule
